// ===== design/bdq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and constants for the bounded deque with indexed read.
// ----------------------------------------------------------------------------
package bdq_pkg;

    // default sizing
    localparam int BDQ_DEPTH     = 256;
    localparam int BDQ_ITEM_BITS = 32;

    // fixed field widths
    localparam int MODE_BITS = 3;
    localparam int POS_BITS  = 8;

    // request opcodes
    typedef enum logic [MODE_BITS-1:0] {
        MODE_INS_HEAD = 3'd0,
        MODE_INS_TAIL = 3'd1,
        MODE_REM_HEAD = 3'd2,
        MODE_REM_TAIL = 3'd3,
        MODE_RD_HEAD  = 3'd4,
        MODE_RD_TAIL  = 3'd5,
        MODE_RD_INDEX = 3'd6
    } mode_t;

    // per-cycle commands broadcast to every cell
    typedef struct packed {
        logic shift_r;   // insert at head: move every element one cell up
        logic shift_l;   // remove head: move every element one cell down
        logic wr_tail;   // write item into the cell at the tail index
        logic load_rd;   // copy element row into the read chain
        logic shift_rd;  // move read chain one cell toward cell zero
    } cell_ctl_t;

endpackage

// ===== design/bdq_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_cell
// One slot of the deque: holds the element at a fixed distance from the head
// and one stage of the read chain that walks elements toward cell zero.
// ----------------------------------------------------------------------------
module bdq_cell
    import bdq_pkg::*;
#(
    parameter int DEPTH     = BDQ_DEPTH,
    parameter int ITEM_BITS = BDQ_ITEM_BITS,
    parameter int INDEX     = 0,
    localparam int IW       = $clog2(DEPTH)
) (
    input  logic                 aclk,
    input  cell_ctl_t            ctl,
    input  logic [ITEM_BITS-1:0] item,
    input  logic [IW-1:0]        tail_idx,
    input  logic [ITEM_BITS-1:0] lower_data,  // element of the cell nearer the head
    input  logic [ITEM_BITS-1:0] upper_data,  // element of the cell nearer the tail
    input  logic [ITEM_BITS-1:0] upper_rd,    // read chain stage nearer the tail
    output logic [ITEM_BITS-1:0] data_out,
    output logic [ITEM_BITS-1:0] rd_out
);

    logic [ITEM_BITS-1:0] data_reg, data_next;
    logic [ITEM_BITS-1:0] rd_reg,   rd_next;

    // element update: shifts have priority, commands never overlap
    always_comb begin
        priority if (ctl.shift_r) begin
            data_next = lower_data;
        end else if (ctl.shift_l) begin
            data_next = upper_data;
        end else if (ctl.wr_tail && (tail_idx == IW'(INDEX))) begin
            data_next = item;
        end else begin
            data_next = data_reg;
        end
    end

    // read chain: parallel load, then shift one cell per cycle
    always_comb begin
        priority if (ctl.load_rd) begin
            rd_next = data_reg;
        end else if (ctl.shift_rd) begin
            rd_next = upper_rd;
        end else begin
            rd_next = rd_reg;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        rd_reg   <= rd_next;
    end

    assign data_out = data_reg;
    assign rd_out   = rd_reg;

endmodule

// ===== design/bdq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_ctrl
// Request decoder, element count, read sequencer and output register.
// ----------------------------------------------------------------------------
module bdq_ctrl
    import bdq_pkg::*;
#(
    parameter int DEPTH     = BDQ_DEPTH,
    parameter int ITEM_BITS = BDQ_ITEM_BITS,
    localparam int IW       = $clog2(DEPTH),
    localparam int CW       = $clog2(DEPTH + 1),
    localparam int S_DW     = ((ITEM_BITS + POS_BITS + 7) / 8) * 8,
    localparam int M_DW     = ((ITEM_BITS + CW + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_DW-1:0]      s_axis_tdata,
    input  logic [MODE_BITS-1:0] s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_DW-1:0]      m_axis_tdata,
    output logic [0:0]           m_axis_tuser,
    output cell_ctl_t            ctl,
    output logic [ITEM_BITS-1:0] item,
    output logic [IW-1:0]        tail_idx,
    input  logic [ITEM_BITS-1:0] rd_head
);

    localparam int CMPW = (POS_BITS > CW) ? POS_BITS : CW;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_READ   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t               state_reg, state_next;
    logic [CW-1:0]        held_reg, held_next;
    logic [IW-1:0]        cnt_reg, cnt_next;
    logic                 res_done_reg, res_done_next;
    logic [ITEM_BITS-1:0] res_val_reg, res_val_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_done_reg, out_done_next;
    logic [ITEM_BITS-1:0] out_val_reg, out_val_next;
    logic [CW-1:0]        out_cnt_reg, out_cnt_next;

    logic                 accept;
    mode_t                mode;
    logic [POS_BITS-1:0]  position;
    logic                 full, empty;
    logic [CW-1:0]        held_m1;
    logic [IW-1:0]        rd_idx;
    logic                 go_read;

    // unpack request
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign mode     = mode_t'(s_axis_tuser);
    assign item     = s_axis_tdata[ITEM_BITS-1:0];
    assign position = s_axis_tdata[ITEM_BITS +: POS_BITS];

    assign full     = (held_reg == CW'(DEPTH));
    assign empty    = (held_reg == '0);
    assign held_m1  = held_reg - CW'(1);
    assign tail_idx = held_reg[IW-1:0];

    assign s_axis_tready = (state_reg == ST_IDLE);

    // sequencer
    always_comb begin
        state_next     = state_reg;
        held_next      = held_reg;
        cnt_next       = cnt_reg;
        res_done_next  = res_done_reg;
        res_val_next   = res_val_reg;
        out_valid_next = out_valid_reg;
        out_done_next  = out_done_reg;
        out_val_next   = out_val_reg;
        out_cnt_next   = out_cnt_reg;
        ctl            = '0;
        rd_idx         = '0;
        go_read        = 1'b0;

        // result taken downstream
        if (out_valid_reg && m_axis_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    res_done_next = 1'b0;
                    res_val_next  = '0;
                    unique case (mode)
                        MODE_INS_HEAD: begin
                            if (!full) begin
                                ctl.shift_r   = 1'b1;
                                held_next     = held_reg + CW'(1);
                                res_done_next = 1'b1;
                            end
                        end
                        MODE_INS_TAIL: begin
                            if (!full) begin
                                ctl.wr_tail   = 1'b1;
                                held_next     = held_reg + CW'(1);
                                res_done_next = 1'b1;
                            end
                        end
                        MODE_REM_HEAD: begin
                            if (!empty) begin
                                ctl.shift_l   = 1'b1;
                                held_next     = held_m1;
                                res_done_next = 1'b1;
                            end
                        end
                        MODE_REM_TAIL: begin
                            if (!empty) begin
                                held_next     = held_m1;
                                res_done_next = 1'b1;
                            end
                        end
                        MODE_RD_HEAD: begin
                            if (!empty) begin
                                go_read = 1'b1;
                            end
                        end
                        MODE_RD_TAIL: begin
                            if (!empty) begin
                                rd_idx  = held_m1[IW-1:0];
                                go_read = 1'b1;
                            end
                        end
                        MODE_RD_INDEX: begin
                            if (CMPW'(position) < CMPW'(held_reg)) begin
                                rd_idx  = IW'(position);
                                go_read = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase

                    if (go_read) begin
                        ctl.load_rd = 1'b1;
                        cnt_next    = rd_idx;
                        state_next  = ST_READ;
                    end else begin
                        state_next  = ST_FINISH;
                    end
                end
            end

            // walk the wanted element down to cell zero
            ST_READ: begin
                if (cnt_reg == '0) begin
                    res_done_next = 1'b1;
                    res_val_next  = rd_head;
                    state_next    = ST_FINISH;
                end else begin
                    ctl.shift_rd = 1'b1;
                    cnt_next     = cnt_reg - IW'(1);
                end
            end

            // hand the result to the output register once it is free
            ST_FINISH: begin
                if (!out_valid_reg || m_axis_tready) begin
                    out_valid_next = 1'b1;
                    out_done_next  = res_done_reg;
                    out_val_next   = res_val_reg;
                    out_cnt_next   = held_reg;
                    state_next     = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        cnt_reg      <= cnt_next;
        res_done_reg <= res_done_next;
        res_val_reg  <= res_val_next;
        out_done_reg <= out_done_next;
        out_val_reg  <= out_val_next;
        out_cnt_reg  <= out_cnt_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = M_DW'({out_cnt_reg, out_val_reg});
    assign m_axis_tuser  = out_done_reg;

endmodule

// ===== design/bounded_deque_with_index_read_top.sv =====
`timescale 1ns / 1ps
// Insert, remove and ignored results go via the FINISH state to the output register;
//   a read at index k (head is 0, tail is count-1) loads the read chain, which moves
//   one cell per cycle toward cell zero, then passes via FINISH to the output register.
// Only one request is in flight: s_axis_tready is high only in the idle state.
// Reset clears the count, the sequencer and the output valid; cell contents are
//   left as they are and become defined as elements are inserted.
// ----------------------------------------------------------------------------
// bounded_deque_with_index_read_top
// Bounded deque built as a row of element cells with head and tail access
// and an indexed read through a shifting read chain.
// ----------------------------------------------------------------------------
module bounded_deque_with_index_read_top
    import bdq_pkg::*;
#(
    parameter int DEPTH     = BDQ_DEPTH,
    parameter int ITEM_BITS = BDQ_ITEM_BITS,
    localparam int IW       = $clog2(DEPTH),
    localparam int CW       = $clog2(DEPTH + 1),
    localparam int S_DW     = ((ITEM_BITS + POS_BITS + 7) / 8) * 8,
    localparam int M_DW     = ((ITEM_BITS + CW + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_DW-1:0]      s_axis_tdata,   // item, position, zero pad
    input  logic [MODE_BITS-1:0] s_axis_tuser,   // mode
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_DW-1:0]      m_axis_tdata,   // read_value, count, zero pad
    output logic [0:0]           m_axis_tuser    // done_res
);

    cell_ctl_t            ctl;
    logic [ITEM_BITS-1:0] item;
    logic [IW-1:0]        tail_idx;
    logic [ITEM_BITS-1:0] cell_data [DEPTH];
    logic [ITEM_BITS-1:0] cell_rd   [DEPTH];

    bdq_ctrl #(
        .DEPTH     (DEPTH),
        .ITEM_BITS (ITEM_BITS)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .ctl           (ctl),
        .item          (item),
        .tail_idx      (tail_idx),
        .rd_head       (cell_rd[0])
    );

    // row of cells, cell 0 holds the head
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [ITEM_BITS-1:0] lower_data;
        logic [ITEM_BITS-1:0] upper_data;
        logic [ITEM_BITS-1:0] upper_rd;

        if (i == 0) begin : g_first
            assign lower_data = item;
        end else begin : g_mid_lo
            assign lower_data = cell_data[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign upper_data = '0;
            assign upper_rd   = '0;
        end else begin : g_mid_hi
            assign upper_data = cell_data[i+1];
            assign upper_rd   = cell_rd[i+1];
        end

        bdq_cell #(
            .DEPTH     (DEPTH),
            .ITEM_BITS (ITEM_BITS),
            .INDEX     (i)
        ) u_cell (
            .aclk       (aclk),
            .ctl        (ctl),
            .item       (item),
            .tail_idx   (tail_idx),
            .lower_data (lower_data),
            .upper_data (upper_data),
            .upper_rd   (upper_rd),
            .data_out   (cell_data[i]),
            .rd_out     (cell_rd[i])
        );
    end

endmodule

// ===== design/bdq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_sva
// Port-level checks for the bounded deque, bound to the top level.
// ----------------------------------------------------------------------------
module bdq_sva
    import bdq_pkg::*;
#(
    parameter int DEPTH     = BDQ_DEPTH,
    parameter int ITEM_BITS = BDQ_ITEM_BITS,
    localparam int CW       = $clog2(DEPTH + 1),
    localparam int M_DW     = ((ITEM_BITS + CW + 7) / 8) * 8
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_DW-1:0]      m_axis_tdata,
    input logic [0:0]           m_axis_tuser
);

    logic [ITEM_BITS-1:0] read_value;
    logic [CW-1:0]        count;

    assign read_value = m_axis_tdata[ITEM_BITS-1:0];
    assign count      = m_axis_tdata[ITEM_BITS +: CW];

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // count never exceeds capacity
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (CW'(DEPTH) >= count))
        else $error("count above depth");

    // a request without effect returns a zero element
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser[0] |-> (read_value == '0))
        else $error("nonzero element on ignored request");

    // one request at a time: busy right after an input transfer
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while busy");

    // reset empties the output register
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind bounded_deque_with_index_read_top bdq_sva #(
    .DEPTH     (DEPTH),
    .ITEM_BITS (ITEM_BITS)
) u_bdq_sva (.*);
